>>> hw/rtl/time_window_statistics_macros.svh
// ----------------------------------------------------------------------------
// time_window_statistics_macros
// Assertion shorthands shared by the window statistics RTL.
// ----------------------------------------------------------------------------
`ifndef TIME_WINDOW_STATISTICS_MACROS_SVH
`define TIME_WINDOW_STATISTICS_MACROS_SVH

// expr holds at every clock edge out of reset
`define TWS_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// ante in this cycle implies cons in the same cycle
`define TWS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante in this cycle implies cons in the next cycle
`define TWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Constants, command codes and status bundle of the window statistics block.
// ----------------------------------------------------------------------------
package tws_pkg;

   localparam int CAPACITY  = 64;
   localparam int SLOTS     = CAPACITY + 1;          // one spare slot before trimming
   localparam int IDX_W     = $clog2(SLOTS);
   localparam int CNT_W     = 7;
   localparam int VAL_W     = 32;
   localparam int TIME_W    = 32;
   localparam int ENTRY_W   = TIME_W + VAL_W;
   localparam int WGT_W     = $clog2(CAPACITY * (CAPACITY + 1) / 2 + 1);
   localparam int SUM_W     = VAL_W + WGT_W;
   localparam int REM_W     = WGT_W + 1;
   localparam int DCNT_W    = $clog2(SUM_W + 1);

   localparam int REQ_W     = 64;
   localparam int RSP_W     = 112;

   // result beat layout
   localparam int RSP_TOTAL_LO = 0;
   localparam int RSP_POP_BIT  = 7;
   localparam int RSP_MEAN_LO  = 8;
   localparam int RSP_QUART_LO = 40;
   localparam int RSP_WMEAN_LO = 72;
   localparam int RSP_SIGN_LO  = 104;
   localparam int RSP_DROP_BIT = 106;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_SPAN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SIZE  = CSR_IDX_W'(1);
   localparam logic [TIME_W-1:0]    TIME_SPAN_RESET = TIME_W'(1000);
   localparam logic [CNT_W-1:0]     MIN_SIZE_RESET  = CNT_W'(1);

   localparam logic REQ_PUSH  = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   localparam logic [1:0] SIGN_NONE = 2'b00;
   localparam logic [1:0] SIGN_POS  = 2'b01;
   localparam logic [1:0] SIGN_NEG  = 2'b11;

   typedef enum logic [5:0] {
      CMD_NONE,
      CMD_START,
      CMD_CLEAR,
      CMD_T_READ,
      CMD_T_STEP,
      CMD_T_PLACE0,
      CMD_S_READ,
      CMD_S_STEP,
      CMD_S_PLACE0,
      CMD_E_READ,
      CMD_V_BEGIN,
      CMD_F_READ,
      CMD_F_STEP,
      CMD_SH_READ,
      CMD_SH_STEP,
      CMD_TS_INIT,
      CMD_TS_READ,
      CMD_TS_STEP,
      CMD_V_END,
      CMD_AGES,
      CMD_A_INIT,
      CMD_A_READ,
      CMD_A_STEP,
      CMD_Q_READA,
      CMD_Q_READB,
      CMD_Q_FIN,
      CMD_D_INIT_MEAN,
      CMD_D_INIT_WMEAN,
      CMD_D_STEP,
      CMD_D_FIN_MEAN,
      CMD_D_FIN_WMEAN,
      CMD_OUT
   } cmd_type;

   typedef struct packed {
      logic ptr_zero;
      logic ptr_last;
      logic t_less;
      logic s_greater;
      logic sv_match;
      logic evict_age;
      logic over_cap;
      logic dropped;
      logic populated;
      logic div_done;
      logic out_busy;
   } status_type;

endpackage

>>> hw/rtl/tws_ctrl.sv
// ----------------------------------------------------------------------------
// tws_ctrl
// Sequencer: walks insert, trim, accumulate, quartile and divide phases per push beat.
// ----------------------------------------------------------------------------
module tws_ctrl
   import tws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T_RD,
      ST_T_STEP,
      ST_S_RD,
      ST_S_STEP,
      ST_E_RD,
      ST_E_CHK,
      ST_F_RD,
      ST_F_STEP,
      ST_SH_RD,
      ST_SH_STEP,
      ST_TS_RD,
      ST_TS_STEP,
      ST_AGES,
      ST_A_INIT,
      ST_A_RD,
      ST_A_STEP,
      ST_Q_A,
      ST_Q_B,
      ST_Q_FIN,
      ST_DM_INIT,
      ST_DM,
      ST_DW_INIT,
      ST_DW,
      ST_WAIT_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = CMD_NONE;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == REQ_CLEAR) begin
                  cmd      = CMD_CLEAR;
                  state_in = ST_WAIT_OUT;
               end else begin
                  cmd      = CMD_START;
                  state_in = ST_T_RD;
               end
            end
         end
         ST_T_RD: begin
            cmd      = status.ptr_zero ? CMD_T_PLACE0 : CMD_T_READ;
            state_in = status.ptr_zero ? ST_S_RD : ST_T_STEP;
         end
         ST_T_STEP: begin
            cmd      = CMD_T_STEP;
            state_in = status.t_less ? ST_T_RD : ST_S_RD;
         end
         ST_S_RD: begin
            cmd      = status.ptr_zero ? CMD_S_PLACE0 : CMD_S_READ;
            state_in = status.ptr_zero ? ST_E_RD : ST_S_STEP;
         end
         ST_S_STEP: begin
            cmd      = CMD_S_STEP;
            state_in = status.s_greater ? ST_S_RD : ST_E_RD;
         end
         ST_E_RD: begin
            cmd      = CMD_E_READ;
            state_in = ST_E_CHK;
         end
         ST_E_CHK: begin
            if (status.evict_age || status.over_cap) begin
               cmd      = CMD_V_BEGIN;
               state_in = ST_F_RD;
            end else begin
               cmd      = CMD_AGES;
               state_in = ST_A_INIT;
            end
         end
         ST_F_RD: begin
            cmd      = CMD_F_READ;
            state_in = ST_F_STEP;
         end
         ST_F_STEP: begin
            cmd      = CMD_F_STEP;
            state_in = status.sv_match ? ST_SH_RD : ST_F_RD;
         end
         ST_SH_RD: begin
            cmd      = status.ptr_last ? CMD_TS_INIT : CMD_SH_READ;
            state_in = status.ptr_last ? ST_TS_RD : ST_SH_STEP;
         end
         ST_SH_STEP: begin
            cmd      = CMD_SH_STEP;
            state_in = ST_SH_RD;
         end
         ST_TS_RD: begin
            if (status.ptr_last) begin
               cmd      = CMD_V_END;
               // a capacity drop ends trimming
               state_in = status.dropped ? ST_AGES : ST_E_RD;
            end else begin
               cmd      = CMD_TS_READ;
               state_in = ST_TS_STEP;
            end
         end
         ST_TS_STEP: begin
            cmd      = CMD_TS_STEP;
            state_in = ST_TS_RD;
         end
         ST_AGES: begin
            cmd      = CMD_AGES;
            state_in = ST_A_INIT;
         end
         ST_A_INIT: begin
            cmd      = status.populated ? CMD_A_INIT : CMD_NONE;
            state_in = status.populated ? ST_A_RD : ST_WAIT_OUT;
         end
         ST_A_RD: begin
            cmd      = CMD_A_READ;
            state_in = ST_A_STEP;
         end
         ST_A_STEP: begin
            cmd      = CMD_A_STEP;
            state_in = status.ptr_last ? ST_Q_A : ST_A_RD;
         end
         ST_Q_A: begin
            cmd      = CMD_Q_READA;
            state_in = ST_Q_B;
         end
         ST_Q_B: begin
            cmd      = CMD_Q_READB;
            state_in = ST_Q_FIN;
         end
         ST_Q_FIN: begin
            cmd      = CMD_Q_FIN;
            state_in = ST_DM_INIT;
         end
         ST_DM_INIT: begin
            cmd      = CMD_D_INIT_MEAN;
            state_in = ST_DM;
         end
         ST_DM: begin
            cmd      = status.div_done ? CMD_D_FIN_MEAN : CMD_D_STEP;
            state_in = status.div_done ? ST_DW_INIT : ST_DM;
         end
         ST_DW_INIT: begin
            cmd      = CMD_D_INIT_WMEAN;
            state_in = ST_DW;
         end
         ST_DW: begin
            cmd      = status.div_done ? CMD_D_FIN_WMEAN : CMD_D_STEP;
            state_in = status.div_done ? ST_WAIT_OUT : ST_DW;
         end
         ST_WAIT_OUT: begin
            cmd      = status.out_busy ? CMD_NONE : CMD_OUT;
            state_in = status.out_busy ? ST_WAIT_OUT : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/tws_datapath.sv
// ----------------------------------------------------------------------------
// tws_datapath
// Window stores, pointers, accumulators, shared divider and result register.
// ----------------------------------------------------------------------------
`include "time_window_statistics_macros.svh"

module tws_datapath
   import tws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [VAL_W-1:0]      req_value,
   input  logic [TIME_W-1:0]     req_time,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_W-1:0]      rsp_tdata
);

   function automatic logic [CNT_W-1:0] min_cnt(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // stores
   logic [ENTRY_W-1:0] tr_mem [SLOTS];
   logic [VAL_W-1:0]   sv_mem [SLOTS];

   logic               tr_we, sv_we, tr_re, sv_re;
   logic [IDX_W-1:0]   tr_wa, tr_ra, sv_wa, sv_ra;
   logic [ENTRY_W-1:0] tr_wd;
   logic [VAL_W-1:0]   sv_wd;

   logic [ENTRY_W-1:0]       tr_rd_ff;
   logic signed [VAL_W-1:0]  sv_rd_ff;

   // registers
   logic [TIME_W-1:0]        time_span_ff, time_span_in;
   logic [CNT_W-1:0]         min_size_ff, min_size_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic [CNT_W-1:0]         ins_ff, ins_in;
   logic [CNT_W-1:0]         pos_age_ff, pos_age_in;
   logic [CNT_W-1:0]         neg_age_ff, neg_age_in;
   logic signed [VAL_W-1:0]  value_ff, value_in;
   logic [TIME_W-1:0]        time_ff, time_in;
   logic [VAL_W-1:0]         rm_ff, rm_in;
   logic                     dropped_ff, dropped_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [SUM_W-1:0]  wsum_ff, wsum_in;
   logic signed [VAL_W-1:0]  qa_ff, qa_in;
   logic [VAL_W-1:0]         mean_ff, mean_in;
   logic [VAL_W-1:0]         quart_ff, quart_in;
   logic [VAL_W-1:0]         wmean_ff, wmean_in;
   logic [SUM_W-1:0]         div_q_ff, div_q_in;
   logic [REM_W-1:0]         div_r_ff, div_r_in;
   logic [WGT_W-1:0]         div_d_ff, div_d_in;
   logic                     div_neg_ff, div_neg_in;
   logic [DCNT_W-1:0]        div_cnt_ff, div_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   // helpers
   logic [IDX_W:0]               ptr_plus;
   logic [IDX_W-1:0]             ptr_next, ptr_prev;
   logic [IDX_W-1:0]             half_n, quarter_n, qa_addr;
   logic [CNT_W:0]               cnt_p1;
   logic [2*CNT_W:0]             pair_prod;
   logic signed [IDX_W:0]        weight;
   logic signed [IDX_W+VAL_W:0]  wprod;
   logic signed [VAL_W:0]        pair_sum, pair_adj;
   logic [REM_W-1:0]             rem_sh;
   logic [SUM_W-1:0]             quo_sh;
   logic [ENTRY_W-1:0]           new_entry;
   logic [TIME_W-1:0]            age_limit;
   logic                         has_pos, has_neg;
   logic [1:0]                   sign_code;

   assign ptr_plus  = {1'b0, ptr_ff} + (IDX_W+1)'(1);
   assign ptr_next  = ptr_plus[IDX_W-1:0];
   assign ptr_prev  = ptr_ff - IDX_W'(1);
   assign half_n    = IDX_W'(count_ff >> 1);
   assign quarter_n = half_n >> 1;
   assign qa_addr   = (quarter_n == '0) ? '0 : quarter_n - IDX_W'(1);
   assign cnt_p1    = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign pair_prod = count_ff * cnt_p1;
   assign weight    = $signed({1'b0, ptr_next});
   assign wprod     = weight * $signed(tr_rd_ff[VAL_W-1:0]);
   assign pair_sum  = (VAL_W+1)'(qa_ff) + (VAL_W+1)'(sv_rd_ff);
   assign pair_adj  = pair_sum + (VAL_W+1)'(pair_sum[VAL_W]);
   assign rem_sh    = {div_r_ff[REM_W-2:0], div_q_ff[SUM_W-1]};
   assign quo_sh    = {div_q_ff[SUM_W-2:0], 1'b0};
   assign new_entry = {time_ff, value_ff};
   assign age_limit = time_ff - time_span_ff;
   assign has_pos   = pos_age_ff < count_ff;
   assign has_neg   = neg_age_ff < count_ff;
   assign sign_code = (has_pos && !has_neg) ? SIGN_POS :
                      (has_neg && !has_pos) ? SIGN_NEG : SIGN_NONE;

   // status toward the sequencer
   always_comb begin
      status.ptr_zero  = (ptr_ff == '0);
      status.ptr_last  = ptr_plus >= (IDX_W+1)'(count_ff);
      status.t_less    = time_ff < tr_rd_ff[ENTRY_W-1:VAL_W];
      status.s_greater = sv_rd_ff > value_ff;
      status.sv_match  = sv_rd_ff == $signed(rm_ff);
      status.evict_age = (count_ff > min_size_ff) && (time_ff >= time_span_ff) &&
                         (tr_rd_ff[ENTRY_W-1:VAL_W] < age_limit);
      status.over_cap  = count_ff > CNT_W'(CAPACITY);
      status.dropped   = dropped_ff;
      status.populated = (count_ff >= min_size_ff) && (count_ff != '0);
      status.div_done  = (div_cnt_ff == '0);
      status.out_busy  = rsp_valid_ff && !rsp_tready;
   end

   // store ports
   always_comb begin
      tr_we = 1'b0; tr_re = 1'b0; tr_wa = ptr_ff; tr_ra = ptr_ff; tr_wd = tr_rd_ff;
      sv_we = 1'b0; sv_re = 1'b0; sv_wa = ptr_ff; sv_ra = ptr_ff; sv_wd = sv_rd_ff;
      case (cmd)
         CMD_T_READ:   begin tr_re = 1'b1; tr_ra = ptr_prev; end
         CMD_T_STEP:   begin
            tr_we = 1'b1;
            tr_wd = status.t_less ? tr_rd_ff : new_entry;
         end
         CMD_T_PLACE0: begin tr_we = 1'b1; tr_wa = '0; tr_wd = new_entry; end
         CMD_S_READ:   begin sv_re = 1'b1; sv_ra = ptr_prev; end
         CMD_S_STEP:   begin
            sv_we = 1'b1;
            sv_wd = status.s_greater ? sv_rd_ff : value_ff;
         end
         CMD_S_PLACE0: begin sv_we = 1'b1; sv_wa = '0; sv_wd = value_ff; end
         CMD_E_READ:   begin tr_re = 1'b1; tr_ra = '0; end
         CMD_F_READ:   begin sv_re = 1'b1; end
         CMD_SH_READ:  begin sv_re = 1'b1; sv_ra = ptr_next; end
         CMD_SH_STEP:  begin sv_we = 1'b1; end
         CMD_TS_READ:  begin tr_re = 1'b1; tr_ra = ptr_next; end
         CMD_TS_STEP:  begin tr_we = 1'b1; end
         CMD_A_READ:   begin tr_re = 1'b1; sv_re = 1'b1; end
         CMD_Q_READA:  begin sv_re = 1'b1; sv_ra = qa_addr; end
         CMD_Q_READB:  begin sv_re = 1'b1; sv_ra = quarter_n; end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tr_we) begin
         tr_mem[tr_wa] <= tr_wd;
      end
      if (tr_re) begin
         tr_rd_ff <= tr_mem[tr_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (sv_we) begin
         sv_mem[sv_wa] <= sv_wd;
      end
      if (sv_re) begin
         sv_rd_ff <= $signed(sv_mem[sv_ra]);
      end
   end

   // next-state logic
   always_comb begin
      logic [CNT_W-1:0] pa;
      logic [CNT_W-1:0] na;
      time_span_in = time_span_ff;
      min_size_in  = min_size_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      ins_in       = ins_ff;
      pos_age_in   = pos_age_ff;
      neg_age_in   = neg_age_ff;
      value_in     = value_ff;
      time_in      = time_ff;
      rm_in        = rm_ff;
      dropped_in   = dropped_ff;
      sum_in       = sum_ff;
      wsum_in      = wsum_ff;
      qa_in        = qa_ff;
      mean_in      = mean_ff;
      quart_in     = quart_ff;
      wmean_in     = wmean_ff;
      div_q_in     = div_q_ff;
      div_r_in     = div_r_ff;
      div_d_in     = div_d_ff;
      div_neg_in   = div_neg_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pa           = pos_age_ff;
      na           = neg_age_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_TIME_SPAN: time_span_in = csr_data[TIME_W-1:0];
            REG_MIN_SIZE:  min_size_in  = csr_data[CNT_W-1:0];
            default: begin
            end
         endcase
      end

      case (cmd)
         CMD_START: begin
            value_in   = $signed(req_value);
            time_in    = req_time;
            ptr_in     = IDX_W'(count_ff);
            ins_in     = '0;
            dropped_in = 1'b0;
         end
         CMD_CLEAR: begin
            count_in   = '0;
            pos_age_in = '0;
            neg_age_in = '0;
            dropped_in = 1'b0;
         end
         CMD_T_STEP: begin
            if (status.t_less) begin
               ptr_in = ptr_prev;
               ins_in = ins_ff + CNT_W'(1);
            end else begin
               ptr_in = IDX_W'(count_ff);
            end
         end
         CMD_T_PLACE0: ptr_in = IDX_W'(count_ff);
         CMD_S_STEP: begin
            if (status.s_greater) begin
               ptr_in = ptr_prev;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_S_PLACE0: count_in = count_ff + CNT_W'(1);
         CMD_V_BEGIN: begin
            rm_in  = tr_rd_ff[VAL_W-1:0];
            ptr_in = '0;
            if (!status.evict_age) begin
               dropped_in = 1'b1;
            end
         end
         CMD_F_STEP: begin
            if (!status.sv_match) begin
               ptr_in = ptr_next;
            end
         end
         CMD_SH_STEP: ptr_in = ptr_next;
         CMD_TS_INIT: ptr_in = '0;
         CMD_TS_STEP: ptr_in = ptr_next;
         CMD_V_END:   count_in = count_ff - CNT_W'(1);
         CMD_AGES: begin
            if (ins_ff <= pa) pa = min_cnt(pa + CNT_W'(1), count_ff);
            if (ins_ff <= na) na = min_cnt(na + CNT_W'(1), count_ff);
            if (value_ff > 0) pa = min_cnt(ins_ff, pa);
            if (value_ff < 0) na = min_cnt(ins_ff, na);
            pos_age_in = pa;
            neg_age_in = na;
         end
         CMD_A_INIT: begin
            sum_in  = '0;
            wsum_in = '0;
            ptr_in  = '0;
         end
         CMD_A_STEP: begin
            sum_in  = sum_ff + SUM_W'(sv_rd_ff);
            wsum_in = wsum_ff + SUM_W'(wprod);
            ptr_in  = ptr_next;
         end
         CMD_Q_READB: qa_in = sv_rd_ff;
         CMD_Q_FIN: begin
            if (count_ff == CNT_W'(1) || half_n[0]) begin
               quart_in = sv_rd_ff;
            end else begin
               quart_in = pair_adj[VAL_W:1];
            end
         end
         CMD_D_INIT_MEAN: begin
            div_neg_in = sum_ff[SUM_W-1];
            div_q_in   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
            div_r_in   = '0;
            div_d_in   = WGT_W'(count_ff);
            div_cnt_in = DCNT_W'(SUM_W);
         end
         CMD_D_INIT_WMEAN: begin
            div_neg_in = wsum_ff[SUM_W-1];
            div_q_in   = wsum_ff[SUM_W-1] ? SUM_W'(-wsum_ff) : SUM_W'(wsum_ff);
            div_r_in   = '0;
            div_d_in   = WGT_W'(pair_prod >> 1);
            div_cnt_in = DCNT_W'(SUM_W);
         end
         CMD_D_STEP: begin
            if (rem_sh >= {1'b0, div_d_ff}) begin
               div_r_in = rem_sh - {1'b0, div_d_ff};
               div_q_in = quo_sh | SUM_W'(1);
            end else begin
               div_r_in = rem_sh;
               div_q_in = quo_sh;
            end
            div_cnt_in = div_cnt_ff - DCNT_W'(1);
         end
         CMD_D_FIN_MEAN: begin
            mean_in = div_neg_ff ? -div_q_ff[VAL_W-1:0] : div_q_ff[VAL_W-1:0];
         end
         CMD_D_FIN_WMEAN: begin
            wmean_in = div_neg_ff ? -div_q_ff[VAL_W-1:0] : div_q_ff[VAL_W-1:0];
         end
         CMD_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_data_in[RSP_TOTAL_LO +: CNT_W] = count_ff;
            rsp_data_in[RSP_POP_BIT]           = status.populated;
            if (status.populated) begin
               rsp_data_in[RSP_MEAN_LO  +: VAL_W] = mean_ff;
               rsp_data_in[RSP_QUART_LO +: VAL_W] = quart_ff;
               rsp_data_in[RSP_WMEAN_LO +: VAL_W] = wmean_ff;
            end
            rsp_data_in[RSP_SIGN_LO +: 2]  = sign_code;
            rsp_data_in[RSP_DROP_BIT]      = dropped_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_span_ff <= TIME_SPAN_RESET;
         min_size_ff  <= MIN_SIZE_RESET;
         count_ff     <= '0;
         pos_age_ff   <= '0;
         neg_age_ff   <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         time_span_ff <= time_span_in;
         min_size_ff  <= min_size_in;
         count_ff     <= count_in;
         pos_age_ff   <= pos_age_in;
         neg_age_ff   <= neg_age_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      ins_ff      <= ins_in;
      value_ff    <= value_in;
      time_ff     <= time_in;
      rm_ff       <= rm_in;
      dropped_ff  <= dropped_in;
      sum_ff      <= sum_in;
      wsum_ff     <= wsum_in;
      qa_ff       <= qa_in;
      mean_ff     <= mean_in;
      quart_ff    <= quart_in;
      wmean_ff    <= wmean_in;
      div_q_ff    <= div_q_in;
      div_r_ff    <= div_r_in;
      div_d_ff    <= div_d_in;
      div_neg_ff  <= div_neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TWS_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(SLOTS), "entry count past spare slot")
   `TWS_ASSERT_NEXT(a_clear_empties, cmd == CMD_CLEAR, count_ff == '0, "clear left entries")
   `TWS_ASSERT_IMPLY(a_div_active, cmd == CMD_D_STEP, div_cnt_ff != '0, "divider overrun")
   `TWS_ASSERT_IMPLY(a_out_free, cmd == CMD_OUT, !rsp_valid_ff || rsp_tready,
                     "result overwritten before taken")

endmodule

>>> hw/rtl/time_window_statistics.sv
// ----------------------------------------------------------------------------
// time_window_statistics
// Time-ordered sample window with mean, lower quartile and weighted mean.
// ----------------------------------------------------------------------------
// Usage:
//   req_* beats carry one push (tuser 0) or one clear (tuser 1). Every beat
//   yields exactly one rsp_* beat with count, population flag, statistics,
//   sign summary and capacity drop flag.
//   csr_* writes time_span (index 0) and min_size (index 1); always ready.
// Sequence per item (one item in flight):
//   clear: the output state registers the result right after accept.
//   push:  the time insert and the sorted insert each walk back with a
//          read and a step state per entry passed; each trimmed entry
//          finds and shifts the sorted store and shifts the time store;
//          then the sign trackers update, accumulation walks all entries,
//          the quartile reads two sorted entries and the bit-serial divider
//          runs twice. The statistics are skipped when not populated.
// Throughput: one item at a time; req_tready returns once the result is
//   registered. Reset: synchronous; window and sign trackers clear, time_span
//   1000, min_size 1. Stall: the next request is taken while the result
//   waits; the block holds before writing the following result.
// ----------------------------------------------------------------------------
module time_window_statistics
   import tws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // sample_value[31:0], sample_time[63:32]
   input  logic [0:0]            req_tuser,   // req_type[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // entry_total[6:0], populated[7],
                                              // mean_value[39:8], lower_quartile[71:40],
                                              // weighted_mean[103:72], sign_summary[105:104],
                                              // capacity_drop[106], zero pad[111:107]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   // config writes are registered directly, no backpressure
   assign csr_ready = 1'b1;

   tws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser[0]),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   tws_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_value  (req_tdata[VAL_W-1:0]),
      .req_time   (req_tdata[VAL_W +: TIME_W]),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> dv/tb_time_window_statistics.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_time_window_statistics
// Self-checking bench for the time-ordered sample window statistics block.
// ----------------------------------------------------------------------------
// Each accepted request beat is run through a behavioral copy of the window
// (time-ordered store, sorted store, sign trackers). The copy produces the
// expected result beat, which is queued. A checker compares every response
// beat field by field against the oldest queued beat. The stimulus is a
// directed block first: extremes, late samples, capacity overflow and clear.
// Then come random phases with several register settings and idle mixes, and
// a back-pressure phase.
// ----------------------------------------------------------------------------
module tb_time_window_statistics;
   import tws_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_WAIT  = 600;     // idle tail before the summary

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;   // sample_value[31:0], sample_time[63:32]
   logic [0:0]            req_tuser;   // req_type[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;   // entry_total, populated, mean, quartile,
                                       // weighted mean, sign, capacity drop
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   time_window_statistics DUT (.*);

   // 10 ns clock
   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // one expected response beat
   typedef struct {
      logic [6:0]         total;
      logic               pop;
      logic signed [31:0] mean;
      logic signed [31:0] quart;
      logic signed [31:0] wmean;
      logic [1:0]         sign;
      logic               drop;
   } stats_beat_type;

   stats_beat_type stats_pending[$];

   // ---- behavioral window state ----
   logic [31:0]        win_span;
   int                 win_min;
   logic [31:0]        win_time[0:SLOTS-1];     // oldest first
   logic signed [31:0] win_val [0:SLOTS-1];
   logic signed [31:0] win_sorted[0:SLOTS-1];   // ascending
   int                 win_cnt;
   int                 pos_age;
   int                 neg_age;

   // bookkeeping
   int errors;
   int beats_in;
   int beats_out;
   int clears_sent;
   int cap_drops_seen;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;       // long receiver hold, counted down in its own process
   int cycle_count;
   logic [31:0] cur_time;

   // drop the oldest entry from both stores
   task automatic win_evict();
      int i;
      i = 0;
      if (win_cnt == 0) return;
      while (i < win_cnt && win_sorted[i] != win_val[0]) i++;
      if (i < win_cnt)
         for (; i + 1 < win_cnt; i++) win_sorted[i] = win_sorted[i + 1];
      for (i = 0; i + 1 < win_cnt; i++) begin
         win_time[i] = win_time[i + 1];
         win_val[i]  = win_val[i + 1];
      end
      win_cnt--;
   endtask

   // place a sample in time order, trim for age and capacity
   task automatic win_push(input logic signed [31:0] v, input logic [31:0] t,
                           output logic drop);
      int pos;
      int ins;
      int i;
      int p;
      logic [31:0] lim;
      pos  = win_cnt;
      ins  = 0;
      drop = 1'b0;
      // late sample sits behind every strictly later entry
      while (pos > 0 && t < win_time[pos - 1]) begin
         pos--;
         ins++;
      end
      for (i = win_cnt; i > pos; i--) begin
         win_time[i] = win_time[i - 1];
         win_val[i]  = win_val[i - 1];
      end
      win_time[pos] = t;
      win_val[pos]  = v;
      p = win_cnt;
      while (p > 0 && win_sorted[p - 1] > v) begin
         win_sorted[p] = win_sorted[p - 1];
         p--;
      end
      win_sorted[p] = v;
      win_cnt++;
      // no age trimming when the span reaches before tick zero
      if (t >= win_span) begin
         lim = t - win_span;
         while (win_cnt > win_min && win_time[0] < lim) win_evict();
      end
      if (win_cnt > CAPACITY) begin
         win_evict();
         drop = 1'b1;
      end
      if (ins <= pos_age) pos_age = (pos_age + 1 < win_cnt) ? pos_age + 1 : win_cnt;
      if (ins <= neg_age) neg_age = (neg_age + 1 < win_cnt) ? neg_age + 1 : win_cnt;
      if (v > 0 && ins < pos_age) pos_age = ins;
      if (v < 0 && ins < neg_age) neg_age = ins;
   endtask

   // advance the window by one request and queue its result
   task automatic predict_stats(input logic kind, input logic signed [31:0] v,
                                input logic [31:0] t);
      stats_beat_type e;
      longint sum;
      longint wsum;
      longint q;
      int h;
      int m;
      int i;
      int s;
      logic drop;
      drop = 1'b0;
      if (kind == REQ_CLEAR) begin
         win_cnt = 0;
         pos_age = 0;
         neg_age = 0;
      end else begin
         win_push(v, t, drop);
      end
      e.total = 7'(win_cnt);
      e.pop   = (win_cnt >= win_min) && (win_cnt > 0);
      e.mean  = '0;
      e.quart = '0;
      e.wmean = '0;
      e.drop  = drop;
      if (e.pop) begin
         sum  = 0;
         wsum = 0;
         for (i = 0; i < win_cnt; i++) begin
            sum  += longint'(win_sorted[i]);
            wsum += longint'(i + 1) * longint'(win_val[i]);
         end
         e.mean  = 32'(sum / longint'(win_cnt));
         e.wmean = 32'(wsum / (longint'(win_cnt) * longint'(win_cnt + 1) / 2));
         h = win_cnt / 2;
         m = h / 2;
         if (win_cnt == 1) q = win_sorted[0];
         else if (h % 2 == 1) q = win_sorted[m];
         else q = (longint'(win_sorted[m - 1]) + longint'(win_sorted[m])) / 2;
         e.quart = 32'(q);
      end
      s = (pos_age < win_cnt ? 1 : 0) - (neg_age < win_cnt ? 1 : 0);
      e.sign = (s > 0) ? SIGN_POS : (s < 0) ? SIGN_NEG : SIGN_NONE;
      stats_pending.push_back(e);
   endtask

   // ---- request driver: one beat, valid held high across back-to-back beats ----
   task automatic send_beat(input logic kind, input logic signed [31:0] v,
                            input logic [31:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom};   // junk while idle
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {t, v};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_stats(kind, v, t);
      beats_in++;
      if (kind == REQ_CLEAR) clears_sent++;
   endtask

   task automatic push_at(input logic signed [31:0] v, input logic [31:0] t);
      send_beat(REQ_PUSH, v, t);
   endtask

   task automatic clear_window();
      send_beat(REQ_CLEAR, $urandom, $urandom);   // sample fields ignored
   endtask

   // sender pause until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (stats_pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, only called with the block drained
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_TIME_SPAN) win_span = val;
      else if (idx == REG_MIN_SIZE) win_min = int'(val[6:0]);
   endtask

   task automatic set_regs(input logic [31:0] span, input int min_sz);
      drain();
      write_reg(REG_TIME_SPAN, span);
      write_reg(REG_MIN_SIZE, 32'(min_sz));
   endtask

   // ---- response checker and receiver back-pressure ----
   task automatic check_beat();
      stats_beat_type e;
      logic bad;
      beats_out++;
      if (stats_pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("ERROR: response beat with nothing expected");
         return;
      end
      e = stats_pending[0];
      stats_pending.delete(0);
      bad = (rsp_tdata[6:0] !== e.total) || (rsp_tdata[7] !== e.pop)
         || (rsp_tdata[39:8] !== e.mean) || (rsp_tdata[71:40] !== e.quart)
         || (rsp_tdata[103:72] !== e.wmean) || (rsp_tdata[105:104] !== e.sign)
         || (rsp_tdata[106] !== e.drop);
      if (rsp_tdata[106] === 1'b1) cap_drops_seen++;
      if (bad) begin
         errors++;
         if (errors <= 10) begin
            $display("ERROR beat %0d: exp total=%0d pop=%0b mean=%h q=%h wm=%h sign=%b drop=%b",
                     beats_out, e.total, e.pop, e.mean, e.quart, e.wmean, e.sign, e.drop);
            $display("               got total=%0d pop=%0b mean=%h q=%h wm=%h sign=%b drop=%b",
                     rsp_tdata[6:0], rsp_tdata[7], rsp_tdata[39:8], rsp_tdata[71:40],
                     rsp_tdata[103:72], rsp_tdata[105:104], rsp_tdata[106]);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_beat();
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold countdown
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---- tests ----
   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      clear_window();                          // clear on an empty window
      push_at(32'sh7FFF_FFFF, 32'd0);          // single entry, tick zero
      push_at(32'sh8000_0000, 32'd5);          // most negative
      push_at(32'sd0, 32'd5);                  // equal time keeps arrival order
      push_at(32'sh0001_0000, 32'd3);          // late sample
      push_at(-32'sh0002_8000, 32'd1);         // late, behind all but the tick-zero entry
      push_at(32'sh0000_0001, 32'd900);        // span still reaches before zero
      push_at(32'sh1234_5678, 32'd2000);       // ages out the early entries
      push_at(-32'sd1, 32'hFFFF_FFFF);         // latest tick, trims all but one
      clear_window();                          // clear resets sign trackers
      push_at(-32'sd7, 32'd10);
      push_at(32'sd9, 32'd11);
      set_regs(32'd0, 0);                      // zero span, zero minimum
      push_at(32'sd4, 32'd100);
      push_at(32'sd5, 32'd100);
      push_at(32'sd6, 32'd101);                // both older ones dropped
      set_regs(32'd50, 3);                     // not populated below three
      clear_window();
      push_at(32'sd100, 32'd1000);
      push_at(-32'sd100, 32'd1001);
      push_at(32'sd300, 32'd1002);
      push_at(32'sd400, 32'd5000);             // minimum keeps three
      clear_window();
   endtask

   // fills past capacity, then a late sample older than all on a full window
   task automatic test_capacity();
      int i;
      set_regs(32'hFFFF_FFFF, 1);
      send_idle_pct  = 10;
      recv_stall_pct = 10;
      for (i = 0; i < 68; i++) push_at($urandom, 32'(1000 + 4 * i));
      push_at(32'sh4000_0000, 32'd10);          // oldest of all, dropped itself
      push_at(-32'sh4000_0000, 32'd1100);       // late into the middle
      set_regs(32'd5, 100);                     // minimum above capacity
      for (i = 0; i < 6; i++) push_at($urandom, 32'(2000 + 50 * i));
      clear_window();
   endtask

   // random content in well-formed time-ordered streams, some noise
   task automatic random_burst(input int count);
      int i;
      int r;
      int bias;
      logic signed [31:0] v;
      bias = $urandom_range(2);
      for (i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 4) begin
            clear_window();
         end else begin
            r = $urandom_range(99);
            if (r < 75) cur_time = cur_time + $urandom_range(20);
            else if (r < 95) cur_time = cur_time - $urandom_range(60);   // late
            else cur_time = $urandom;
            v = $urandom;
            if ($urandom_range(3) != 0) begin
               if (bias == 1) v = {1'b0, v[30:0]};
               if (bias == 2) v = {1'b1, v[30:0]};
            end
            if ($urandom_range(9) == 0) v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            push_at(v, cur_time);
         end
      end
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct);
      int k;
      logic [31:0] span;
      int min_sz;
      for (k = 0; k < 3; k++) begin
         case ($urandom_range(4))
            0: span = 32'd0;
            1: span = 32'hFFFF_FFFF;
            2: span = $urandom;
            default: span = $urandom_range(300);
         endcase
         case ($urandom_range(5))
            0: min_sz = 0;
            1: min_sz = 64;
            2: min_sz = 127;
            default: min_sz = $urandom_range(8);
         endcase
         set_regs(span, min_sz);
         send_idle_pct  = idle_pct;
         recv_stall_pct = stall_pct;
         random_burst(70);
      end
   endtask

   // receiver holds off long while requests keep coming
   task automatic test_backpressure();
      int i;
      set_regs(32'd200, 2);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      hold_cycles = 2000;
      for (i = 0; i < 12; i++) push_at($urandom, cur_time + 32'(i));
      drain();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      errors      = 0;
      beats_in    = 0;
      beats_out   = 0;
      clears_sent = 0;
      cap_drops_seen = 0;
      hold_cycles = 0;
      cycle_count = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      cur_time    = 32'd5000;
      win_span    = TIME_SPAN_RESET;
      win_min     = int'(MIN_SIZE_RESET);
      win_cnt     = 0;
      pos_age     = 0;
      neg_age     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_capacity();
      test_random_phase(0, 0);
      test_random_phase(71, 0);
      test_random_phase(0, 71);
      test_random_phase(28, 28);
      test_backpressure();

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Covered %0d request beats (%0d clears), %0d responses, %0d capacity drops,",
               beats_in, clears_sent, beats_out, cap_drops_seen);
      $display("over several span/minimum settings and idle/stall mixes; %0d mismatches",
               errors + stats_pending.size());
      if (errors == 0 && stats_pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tws_pkg.sv
hw/rtl/tws_ctrl.sv
hw/rtl/tws_datapath.sv
hw/rtl/time_window_statistics.sv
dv/tb_time_window_statistics.sv
